[sv/sat_rectangle_collision_scan_macros.svh]
// ----------------------------------------------------------------------------
// srcs assertion macros
// shared concurrent assertion forms for the collision scan block
// ----------------------------------------------------------------------------
`ifndef SAT_RECTANGLE_COLLISION_SCAN_MACROS_SVH
`define SAT_RECTANGLE_COLLISION_SCAN_MACROS_SVH

// same-cycle implication, checked outside reset
`define SRCS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srcs assertion failed");

// next-cycle implication, checked outside reset
`define SRCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srcs assertion failed");

`endif

[sv/srcs_pkg.sv]
// ----------------------------------------------------------------------------
// srcs_pkg
// types and constants of the rectangle collision scan
// ----------------------------------------------------------------------------
package srcs_pkg;

   localparam int MAX_BODIES = 32;
   localparam int COORD_BITS = 16;
   localparam int IDX_W      = $clog2(MAX_BODIES);
   localparam int CNT_W      = $clog2(MAX_BODIES + 1);
   localparam int OUT_IDX_W  = 5;
   localparam int CORNERS    = 4;
   localparam int AXES       = 4;
   localparam int SHAPES     = 2;
   localparam int REQ_DATA_W = ((2 * CORNERS * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * OUT_IDX_W + 7) / 8) * 8;
   localparam int AXIS_W     = COORD_BITS + 1;
   localparam int PROD_W     = AXIS_W + COORD_BITS;
   localparam int DOT_W      = PROD_W + 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   // corners a, b, c, d in slots 0..3
   typedef struct packed {
      coord_type [CORNERS-1:0] x;
      coord_type [CORNERS-1:0] z;
   } rect_type;

   // marker that travels with each pair test
   typedef struct packed {
      logic             valid;
      logic             flush;
      logic [IDX_W-1:0] idx;
   } tag_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OVF,
      ST_SCAN,
      ST_FLUSH,
      ST_WAIT
   } state_type;

endpackage

[sv/srcs_ring_cell.sv]
// ----------------------------------------------------------------------------
// srcs_ring_cell
// one stored rectangle; passes its contents to the neighbor when rotating
// ----------------------------------------------------------------------------
module srcs_ring_cell (
   input  logic               clock,
   input  logic               shift_en,
   input  srcs_pkg::rect_type nbr_rect,
   input  logic               wr_en,
   input  srcs_pkg::rect_type wr_rect,
   output srcs_pkg::rect_type rect
);

   srcs_pkg::rect_type rect_ff;
   srcs_pkg::rect_type rect_in;

   // rotate, load a new body, or hold
   always_comb begin
      rect_in = rect_ff;
      if (shift_en) begin
         rect_in = nbr_rect;
      end else if (wr_en) begin
         rect_in = wr_rect;
      end
   end

   always_ff @(posedge clock) begin
      rect_ff <= rect_in;
   end

   assign rect = rect_ff;

endmodule

[sv/srcs_pair_test.sv]
// ----------------------------------------------------------------------------
// srcs_pair_test
// five-stage separating axis test of the new rectangle against one stored one
// ----------------------------------------------------------------------------
module srcs_pair_test (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  srcs_pkg::tag_type  in_tag,
   input  srcs_pkg::rect_type new_rect,
   input  srcs_pkg::rect_type old_rect,
   output srcs_pkg::tag_type  out_tag,
   output logic               out_hit
);

   localparam int NA = srcs_pkg::AXES;
   localparam int NS = srcs_pkg::SHAPES;
   localparam int NC = srcs_pkg::CORNERS;

   // tag pipeline
   srcs_pkg::tag_type tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff;

   // stage 1: axes and corner copies
   logic signed [srcs_pkg::AXIS_W-1:0]     axx1_ff [NA];
   logic signed [srcs_pkg::AXIS_W-1:0]     axz1_ff [NA];
   logic signed [srcs_pkg::AXIS_W-1:0]     axx1_in [NA];
   logic signed [srcs_pkg::AXIS_W-1:0]     axz1_in [NA];
   logic signed [srcs_pkg::COORD_BITS-1:0] px1_ff [NS][NC];
   logic signed [srcs_pkg::COORD_BITS-1:0] pz1_ff [NS][NC];
   logic signed [srcs_pkg::COORD_BITS-1:0] px1_in [NS][NC];
   logic signed [srcs_pkg::COORD_BITS-1:0] pz1_in [NS][NC];

   // stage 2: products
   logic signed [srcs_pkg::PROD_W-1:0] mx2_ff [NA][NS][NC];
   logic signed [srcs_pkg::PROD_W-1:0] mz2_ff [NA][NS][NC];

   // stage 3: projections
   logic signed [srcs_pkg::DOT_W-1:0] dot3_ff [NA][NS][NC];

   // stage 4: projected ranges
   logic signed [srcs_pkg::DOT_W-1:0] lo4_ff [NA][NS];
   logic signed [srcs_pkg::DOT_W-1:0] hi4_ff [NA][NS];
   logic signed [srcs_pkg::DOT_W-1:0] lo4_in [NA][NS];
   logic signed [srcs_pkg::DOT_W-1:0] hi4_in [NA][NS];

   // stage 5: verdict
   logic hit5_ff;
   logic hit5_in;

   // axes b-a and c-a of both shapes
   always_comb begin
      for (int s = 0; s < NS; s++) begin
         for (int k = 0; k < NC; k++) begin
            px1_in[s][k] = (s == 0) ? $signed(new_rect.x[k]) : $signed(old_rect.x[k]);
            pz1_in[s][k] = (s == 0) ? $signed(new_rect.z[k]) : $signed(old_rect.z[k]);
         end
      end
      for (int a = 0; a < NA; a++) begin
         axx1_in[a] = srcs_pkg::AXIS_W'(px1_in[a/2][1 + (a%2)])
                    - srcs_pkg::AXIS_W'(px1_in[a/2][0]);
         axz1_in[a] = srcs_pkg::AXIS_W'(pz1_in[a/2][1 + (a%2)])
                    - srcs_pkg::AXIS_W'(pz1_in[a/2][0]);
      end
   end

   // min and max of four projections
   always_comb begin
      for (int a = 0; a < NA; a++) begin
         for (int s = 0; s < NS; s++) begin
            lo4_in[a][s] = dot3_ff[a][s][0];
            hi4_in[a][s] = dot3_ff[a][s][0];
            for (int k = 1; k < NC; k++) begin
               if (dot3_ff[a][s][k] < lo4_in[a][s]) lo4_in[a][s] = dot3_ff[a][s][k];
               if (dot3_ff[a][s][k] > hi4_in[a][s]) hi4_in[a][s] = dot3_ff[a][s][k];
            end
         end
      end
   end

   // strict overlap on every axis
   always_comb begin
      hit5_in = 1'b1;
      for (int a = 0; a < NA; a++) begin
         if (!((lo4_ff[a][1] < hi4_ff[a][0]) && (lo4_ff[a][0] < hi4_ff[a][1]))) begin
            hit5_in = 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (adv) begin
         axx1_ff <= axx1_in;
         axz1_ff <= axz1_in;
         px1_ff  <= px1_in;
         pz1_ff  <= pz1_in;
         for (int a = 0; a < NA; a++) begin
            for (int s = 0; s < NS; s++) begin
               for (int k = 0; k < NC; k++) begin
                  mx2_ff[a][s][k]  <= axx1_ff[a] * px1_ff[s][k];
                  mz2_ff[a][s][k]  <= axz1_ff[a] * pz1_ff[s][k];
                  dot3_ff[a][s][k] <= srcs_pkg::DOT_W'(mx2_ff[a][s][k])
                                    + srcs_pkg::DOT_W'(mz2_ff[a][s][k]);
               end
            end
         end
         lo4_ff  <= lo4_in;
         hi4_ff  <= hi4_in;
         hit5_ff <= hit5_in;
      end
   end

   // tag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
         tag5_ff <= '0;
      end else if (adv) begin
         tag1_ff <= in_tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
         tag5_ff <= tag4_ff;
      end
   end

   assign out_tag = tag5_ff;
   assign out_hit = hit5_ff;

endmodule

[sv/sat_rectangle_collision_scan.sv]
// An item is scanned by one full turn of the ring of stored bodies past the
// pair test unit, plus its five stages and a flush beat; an overflow item
// only sends an overflow response. A new item is taken only from idle.
// Results leave at most one per cycle, while the output register is not stalled;
// a hit is held until the next hit or the flush beat tells whether it is the last.
// Reset empties the store (body count zero) and clears the pipeline and output.
// ----------------------------------------------------------------------------
// sat_rectangle_collision_scan
// separating axis collision scan of oriented rectangles within a frame
// ----------------------------------------------------------------------------
`include "sat_rectangle_collision_scan_macros.svh"

module sat_rectangle_collision_scan (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // ax, az, bx, bz, cx, cz, dx, dz
   input  logic [srcs_pkg::REQ_DATA_W-1:0]     req_tdata,
   // first_of_frame
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // new_index, other_index, zero pad
   output logic [srcs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // overflow
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);

   localparam int N = srcs_pkg::MAX_BODIES;
   localparam int C = srcs_pkg::COORD_BITS;

   srcs_pkg::state_type state_ff, state_in;
   logic [srcs_pkg::CNT_W-1:0] count_ff, count_in;
   logic [srcs_pkg::IDX_W-1:0] step_ff, step_in;
   srcs_pkg::rect_type         new_rect_ff, new_rect_in, req_rect;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [srcs_pkg::OUT_IDX_W-1:0] rsp_new_ff, rsp_new_in;
   logic [srcs_pkg::OUT_IDX_W-1:0] rsp_other_ff, rsp_other_in;
   logic                           rsp_ovf_ff, rsp_ovf_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                       pend_valid_ff, pend_valid_in;
   logic [srcs_pkg::IDX_W-1:0] pend_other_ff, pend_other_in;

   logic              adv;
   logic              shift_en;
   logic              store_en;
   srcs_pkg::tag_type issue_tag;
   srcs_pkg::tag_type out_tag;
   logic              out_hit;

   srcs_pkg::rect_type cell_rect [N];

   // unpack the corners
   always_comb begin
      for (int k = 0; k < srcs_pkg::CORNERS; k++) begin
         req_rect.x[k] = req_tdata[(2*k)*C +: C];
         req_rect.z[k] = req_tdata[(2*k+1)*C +: C];
      end
   end

   // pipeline and scan step only when the output register can take a transfer; idle still takes requests
   assign adv = !rsp_valid_ff || rsp_tready;

   // ring of stored bodies, cell 0 feeds the pair test
   for (genvar g = 0; g < N; g++) begin : g_ring
      srcs_ring_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .nbr_rect (cell_rect[(g + 1) % N]),
         .wr_en    (store_en && (count_ff[srcs_pkg::IDX_W-1:0] == srcs_pkg::IDX_W'(g))),
         .wr_rect  (new_rect_ff),
         .rect     (cell_rect[g])
      );
   end

   srcs_pair_test u_test (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_tag   (issue_tag),
      .new_rect (new_rect_ff),
      .old_rect (cell_rect[0]),
      .out_tag  (out_tag),
      .out_hit  (out_hit)
   );

   // sequencer, result ordering and output register
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      new_rect_in   = new_rect_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_new_in    = rsp_new_ff;
      rsp_other_in  = rsp_other_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_last_in   = rsp_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_other_in = pend_other_ff;
      issue_tag     = '0;
      shift_en      = 1'b0;
      store_en      = 1'b0;
      req_tready    = 1'b0;

      case (state_ff)
         srcs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               new_rect_in = req_rect;
               count_in    = req_tuser ? '0 : count_ff;
               if (count_in >= srcs_pkg::CNT_W'(N)) begin
                  state_in = srcs_pkg::ST_OVF;
               end else begin
                  state_in = srcs_pkg::ST_SCAN;
                  step_in  = '0;
               end
            end
         end
         srcs_pkg::ST_OVF: begin
            if (adv) begin
               rsp_valid_in = 1'b1;
               rsp_new_in   = '0;
               rsp_other_in = '0;
               rsp_ovf_in   = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = srcs_pkg::ST_IDLE;
            end
         end
         srcs_pkg::ST_SCAN: begin
            if (adv) begin
               issue_tag.valid = srcs_pkg::CNT_W'(step_ff) < count_ff;
               issue_tag.idx   = step_ff;
               shift_en        = 1'b1;
               step_in         = step_ff + 1'b1;
               if (step_ff == srcs_pkg::IDX_W'(N - 1)) begin
                  state_in = srcs_pkg::ST_FLUSH;
               end
            end
         end
         srcs_pkg::ST_FLUSH: begin
            if (adv) begin
               issue_tag.flush = 1'b1;
               state_in        = srcs_pkg::ST_WAIT;
            end
         end
         srcs_pkg::ST_WAIT: begin
            if (adv && out_tag.flush) begin
               store_en = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = srcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srcs_pkg::ST_IDLE;
         end
      endcase

      // a hit releases the previous one, held back until last is known
      if (adv && out_tag.valid && out_hit) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_new_in   = srcs_pkg::OUT_IDX_W'(count_ff);
            rsp_other_in = srcs_pkg::OUT_IDX_W'(pend_other_ff);
            rsp_ovf_in   = 1'b0;
            rsp_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_other_in = out_tag.idx;
      end

      // flush beat sends the held hit as the final one
      if (adv && out_tag.flush && pend_valid_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_new_in    = srcs_pkg::OUT_IDX_W'(count_ff);
         rsp_other_in  = srcs_pkg::OUT_IDX_W'(pend_other_ff);
         rsp_ovf_in    = 1'b0;
         rsp_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= srcs_pkg::ST_IDLE;
         count_ff      <= '0;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         step_ff       <= step_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      new_rect_ff   <= new_rect_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_other_ff  <= rsp_other_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_last_ff   <= rsp_last_in;
      pend_other_ff <= pend_other_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = srcs_pkg::RSP_DATA_W'({rsp_other_ff, rsp_new_ff});
   assign rsp_tuser  = rsp_ovf_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `SRCS_ASSERT_IMPLIES(a_idle_nothing_held, clock, reset, req_tready, !pend_valid_ff)
   `SRCS_ASSERT_IMPLIES(a_count_in_range, clock, reset, 1'b1, count_ff <= srcs_pkg::CNT_W'(N))
   `SRCS_ASSERT_IMPLIES(a_overflow_is_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast)
   `SRCS_ASSERT_IMPLIES(a_pair_order, clock, reset, rsp_tvalid && !rsp_tuser, rsp_other_ff < rsp_new_ff)
   `SRCS_ASSERT_NEXT(a_store_grows, clock, reset, store_en, count_ff == $past(count_ff) + 1'b1)

endmodule
